### rtl/core/ftec_pkg.sv
package ftec_pkg;

	// Filter order; the filter has ORDER + 1 taps and a centered group delay.
	localparam int ORDER     = 30;
	localparam int NTAPS     = ORDER + 1;
	localparam int DELAY     = ORDER / 2;
	localparam int TAP_W     = $clog2(NTAPS);
	localparam int OFF_W     = $clog2(DELAY + 1);
	localparam int SUM_W     = $clog2(DELAY + ORDER + 1);
	localparam int IDX_BITS  = 5;
	localparam int COEF_BITS = 18;
	localparam int FRAC_BITS = 16;

	// Item kinds carried in the input selector.
	localparam logic FUNC_COEF   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic             tap_we;
		logic             shift;
		logic             clear_line;
		logic             issue;
		logic             first;
		logic             last_tap;
		logic [TAP_W-1:0] k;
		logic [OFF_W-1:0] off;
		logic             load_out;
		logic             run_last;
		logic             trace_done;
	} cmd_t;

	// Status from the datapath back to the sequencer.
	typedef struct packed {
		logic mac_done;
		logic out_free;
	} stat_t;

endpackage

### rtl/core/ftec_datapath.sv
module ftec_datapath #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  ftec_pkg::cmd_t                           cmd,
	output ftec_pkg::stat_t                          stat,
	input  logic [ftec_pkg::IDX_BITS-1:0]            coef_index,
	input  logic signed [ftec_pkg::COEF_BITS-1:0]    coef_value,
	input  logic signed [SAMPLE_BITS-1:0]            sample,
	input  logic                                     out_tready,
	output logic                                     out_tvalid,
	output logic signed [SAMPLE_BITS-1:0]            filtered,
	output logic                                     saturated,
	output logic                                     run_last,
	output logic                                     trace_done
);
	import ftec_pkg::*;

	localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
	localparam int ACC_W  = PROD_W + TAP_W;
	localparam int Q_W    = ACC_W + 1 - FRAC_BITS;
	localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);
	localparam logic signed [SAMPLE_BITS-1:0] MAXV = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] MINV = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

	logic signed [COEF_BITS-1:0]   tap_q [NTAPS];
	logic signed [SAMPLE_BITS-1:0] dl_q  [NTAPS];

	logic [SUM_W-1:0] pos_sum;
	logic [TAP_W-1:0] rd_idx;

	logic                          vld_s1, last_s1, first_s1;
	logic signed [COEF_BITS-1:0]   tap_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic                          vld_s2, last_s2, first_s2;
	logic signed [PROD_W-1:0]      prod_s2;
	logic signed [ACC_W-1:0]       acc_q;
	logic                          done_q;

	logic [ACC_W:0]         rnd;
	logic [Q_W-1:0]         qv;
	logic                   clip;
	logic [SAMPLE_BITS-1:0] sat_val;

	logic                   out_valid_q, sat_q, rl_q, td_q;
	logic [SAMPLE_BITS-1:0] filt_q;

	// Tap store: written by coefficient items, no reset.
	always_ff @(posedge clk) begin
		if (cmd.tap_we && coef_index <= IDX_BITS'(ORDER)) begin
			tap_q[coef_index[TAP_W-1:0]] <= coef_value;
		end
	end

	// Delay line, newest sample at index zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NTAPS; i++) dl_q[i] <= '0;
		end else if (cmd.clear_line) begin
			for (int i = 0; i < NTAPS; i++) dl_q[i] <= '0;
		end else if (cmd.shift) begin
			dl_q[0] <= sample;
			for (int i = 1; i < NTAPS; i++) dl_q[i] <= dl_q[i-1];
		end
	end

	// Sample index off - DELAY + k, clamped at the newest sample.
	assign pos_sum = SUM_W'(cmd.off) + SUM_W'(cmd.k);
	always_comb begin
		if (pos_sum < SUM_W'(DELAY)) begin
			rd_idx = '0;
		end else begin
			rd_idx = TAP_W'(pos_sum - SUM_W'(DELAY));
		end
	end

	// Multiply-accumulate pipeline: operand fetch, product, accumulate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			done_q <= vld_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		tap_s1   <= tap_q[cmd.k];
		smp_s1   <= dl_q[rd_idx];
		first_s1 <= cmd.first;
		last_s1  <= cmd.last_tap;
		prod_s2  <= tap_s1 * smp_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		if (vld_s2) begin
			if (first_s2) begin
				acc_q <= {{TAP_W{prod_s2[PROD_W-1]}}, prod_s2};
			end else begin
				acc_q <= acc_q + {{TAP_W{prod_s2[PROD_W-1]}}, prod_s2};
			end
		end
	end

	// Round half up, then clip to the sample width.
	always_comb begin
		rnd     = {acc_q[ACC_W-1], acc_q} + HALF;
		qv      = rnd[ACC_W:FRAC_BITS];
		clip    = !((&qv[Q_W-1:SAMPLE_BITS-1]) || !(|qv[Q_W-1:SAMPLE_BITS-1]));
		sat_val = qv[Q_W-1] ? MINV : MAXV;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			filt_q <= clip ? sat_val : qv[SAMPLE_BITS-1:0];
			sat_q  <= clip;
			rl_q   <= cmd.run_last;
			td_q   <= cmd.trace_done;
		end
	end

	assign out_tvalid    = out_valid_q;
	assign filtered      = filt_q;
	assign saturated     = sat_q;
	assign run_last      = rl_q;
	assign trace_done    = td_q;
	assign stat.mac_done = done_q;
	assign stat.out_free = !out_valid_q || out_tready;

	a_done_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(vld_s2, 1) && $past(vld_s1, 2))
		else $error("accumulate done without a finished tap sequence");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_tready |-> !cmd.load_out)
		else $error("output register overwritten while held");

	a_no_clear_during_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_line |-> !cmd.shift && !cmd.issue)
		else $error("delay line cleared while in use");

endmodule

### rtl/core/ftec_ctrl.sv
module ftec_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_tvalid,
	output logic            in_tready,
	input  logic            in_func,
	input  logic            in_last,
	input  ftec_pkg::stat_t stat,
	output ftec_pkg::cmd_t  cmd
);
	import ftec_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_DRAIN,
		S_PUT
	} state_t;

	state_t           state_q;
	logic [TAP_W-1:0] k_q;
	logic [OFF_W-1:0] off_q;
	logic [OFF_W-1:0] warm_q;
	logic             flush_q;
	logic             accept;
	logic             final_res;

	assign in_tready = (state_q == S_IDLE);
	assign accept    = in_tvalid && in_tready;
	assign final_res = flush_q && (off_q == '0);

	always_comb begin
		cmd            = '0;
		cmd.tap_we     = accept && (in_func == FUNC_COEF);
		cmd.shift      = accept && (in_func == FUNC_SAMPLE);
		cmd.issue      = (state_q == S_ISSUE);
		cmd.first      = (k_q == '0);
		cmd.last_tap   = (k_q == TAP_W'(ORDER));
		cmd.k          = k_q;
		cmd.off        = off_q;
		cmd.load_out   = (state_q == S_PUT) && stat.out_free;
		cmd.run_last   = !flush_q || final_res;
		cmd.trace_done = final_res;
		cmd.clear_line = cmd.load_out && final_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			off_q   <= '0;
			warm_q  <= '0;
			flush_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					k_q <= '0;
					if (accept && in_func == FUNC_SAMPLE) begin
						if (in_last) begin
							off_q   <= warm_q;
							flush_q <= 1'b1;
							warm_q  <= '0;
							state_q <= S_ISSUE;
						end else if (warm_q == OFF_W'(DELAY)) begin
							off_q   <= OFF_W'(DELAY);
							flush_q <= 1'b0;
							state_q <= S_ISSUE;
						end else begin
							warm_q <= warm_q + OFF_W'(1);
						end
					end
				end
				S_ISSUE: begin
					if (k_q == TAP_W'(ORDER)) begin
						k_q     <= '0;
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + TAP_W'(1);
					end
				end
				S_DRAIN: begin
					if (stat.mac_done) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (stat.out_free) begin
						if (flush_q && off_q != '0) begin
							off_q   <= off_q - OFF_W'(1);
							state_q <= S_ISSUE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_warm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		warm_q <= OFF_W'(DELAY))
		else $error("warmup count beyond group delay");

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		stat.mac_done |-> state_q == S_DRAIN)
		else $error("accumulate finished outside of drain");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result loaded into a full output register");

	a_clear_ends_trace: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_line |=> state_q == S_IDLE && warm_q == '0)
		else $error("trace end did not return to idle");

endmodule

### rtl/core/fir_trace_filter_edge_clamp_unit.sv
// Channel   Dir  Handshake                Payload
// s_axis    in   s_axis_tvalid/tready     tdata: coef_index, coef_value, sample
//                                         tuser: func, tlast: trace_last
// m_axis    out  m_axis_tvalid/tready     tdata: filtered
//                                         tuser: saturated, trace_done; tlast: run_last
//
// A coefficient item and a sample item that causes no result leave the sequencer idle.
// For each result the single shared multiply-accumulate walks all taps one per cycle,
// then the products pass the pipeline stages operand fetch, product and accumulate,
// and the sum is loaded into the output register.
// A trace end item yields up to ORDER/2 + 1 results one after another, with no input
// taken in between, then clears the delay line in the cycle of its last result.
// Reset (arst_n low) clears the delay line, the warmup count and all control state;
// the tap store holds no reset value. A stalled output holds the sequencer; input
// is taken only while the sequencer is idle, also while a result waits.
module fir_trace_filter_edge_clamp_unit #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata, from bit 0 up: coef_index (5), coef_value (18), sample (SAMPLE_BITS), zero fill.
	input  logic [((23 + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// tuser: func (1).
	input  logic s_axis_tuser,
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// tdata, from bit 0 up: filtered (SAMPLE_BITS), zero fill.
	output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// tuser, from bit 0 up: saturated (1), trace_done (1).
	output logic [1:0] m_axis_tuser,
	output logic m_axis_tlast
);
	import ftec_pkg::*;

	localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int SMP_LO = IDX_BITS + COEF_BITS;

	cmd_t  cmd;
	stat_t stat;

	logic [SAMPLE_BITS-1:0] filtered;
	logic                   saturated;
	logic                   trace_done;

	// The sequencer owns the handshake on the input side and the tap walk.
	ftec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tready (s_axis_tready),
		.in_func   (s_axis_tuser),
		.in_last   (s_axis_tlast),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage, the multiply-accumulate pipeline and the output register.
	ftec_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.coef_index (s_axis_tdata[IDX_BITS-1:0]),
		.coef_value (s_axis_tdata[SMP_LO-1:IDX_BITS]),
		.sample     (s_axis_tdata[SMP_LO+SAMPLE_BITS-1:SMP_LO]),
		.out_tready (m_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.filtered   (filtered),
		.saturated  (saturated),
		.run_last   (m_axis_tlast),
		.trace_done (trace_done)
	);

	// Output fields packed onto the master side; unused tdata bits read zero.
	assign m_axis_tdata = OUT_W'(filtered);
	assign m_axis_tuser = {trace_done, saturated};

endmodule
